### rtl/lpsc_pkg.sv
package lpsc_pkg;

  // Framing phase of the header parser
  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } lpsc_phase_t;

  localparam int unsigned LEN_BYTES    = 4;
  localparam int unsigned LEN_BITS     = 32;
  localparam int unsigned SIZE_IN_BITS = 24;
  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned QPTR_BITS    = $clog2(QDEPTH);

  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // Command passed from the parser to the emitter
  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } lpsc_cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } lpsc_qstat_t;

endpackage

### rtl/lpsc_front.sv
module lpsc_front import lpsc_pkg::*; #(
  parameter int unsigned SAMPLE_SIZE_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  logic [7:0]              data_byte,
  input  logic                    first_of_sample,
  input  logic [SIZE_IN_BITS-1:0] sample_size,
  output logic                    push,
  output lpsc_cmd_t               push_cmd
);

  localparam int unsigned SSB = SAMPLE_SIZE_BITS;

  lpsc_phase_t          phase, phase_next, phase_eff;
  logic [1:0]           length_bytes_seen, length_bytes_seen_next, seen_eff;
  logic [LEN_BITS-1:0]  length_accumulator, length_accumulator_next, acc_eff;
  logic [SSB-1:0]       sample_bytes_left, sample_bytes_left_next, left_eff;
  logic [LEN_BITS-1:0]  payload_bytes_left, payload_bytes_left_next, pay_eff;

  logic [31:0]          size_w;
  logic [SSB-1:0]       size_m;
  logic [SSB-1:0]       left_dec;
  logic [LEN_BITS-1:0]  acc_full;
  logic                 active;
  logic                 hdr_done;
  logic                 fits;
  logic                 restart;

  assign restart   = in_fire && first_of_sample;
  assign size_w    = 32'(sample_size);
  assign size_m    = size_w[SSB-1:0];
  assign left_eff  = restart ? size_m : sample_bytes_left;
  assign phase_eff = restart ? PH_LENGTH : phase;
  assign seen_eff  = restart ? 2'd0 : length_bytes_seen;
  assign acc_eff   = restart ? '0 : length_accumulator;
  assign pay_eff   = restart ? '0 : payload_bytes_left;
  assign active    = in_fire && (left_eff != '0);
  assign left_dec  = left_eff - 1'b1;
  assign acc_full  = {acc_eff[LEN_BITS-9:0], data_byte};
  assign hdr_done  = (phase_eff == PH_LENGTH) && (seen_eff == 2'(LEN_BYTES - 1));
  assign fits      = acc_full <= LEN_BITS'(left_dec);

  // Next state
  always_comb begin
    phase_next              = phase_eff;
    length_bytes_seen_next  = seen_eff;
    length_accumulator_next = acc_eff;
    sample_bytes_left_next  = left_eff;
    payload_bytes_left_next = pay_eff;
    if (active) begin
      sample_bytes_left_next = left_dec;
      case (phase_eff)
        PH_LENGTH: begin
          if (!hdr_done) begin
            length_accumulator_next = acc_full;
            length_bytes_seen_next  = seen_eff + 2'd1;
          end else begin
            length_bytes_seen_next  = 2'd0;
            length_accumulator_next = '0;
            if (fits) begin
              payload_bytes_left_next = acc_full;
              phase_next = (acc_full == '0) ? PH_LENGTH : PH_PAYLOAD;
            end else begin
              phase_next = PH_DROP;
            end
          end
        end
        PH_PAYLOAD: begin
          payload_bytes_left_next = pay_eff - 1'b1;
          if (pay_eff == LEN_BITS'(1)) begin
            phase_next              = PH_LENGTH;
            length_bytes_seen_next  = 2'd0;
            length_accumulator_next = '0;
          end
        end
        default: begin
          phase_next = phase_eff;
        end
      endcase
    end
  end

  // Outputs toward the queue
  always_comb begin
    push          = 1'b0;
    push_cmd.start = 1'b0;
    push_cmd.data  = data_byte;
    if (active) begin
      case (phase_eff)
        PH_LENGTH: begin
          if (hdr_done && fits) begin
            push           = 1'b1;
            push_cmd.start = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          push = 1'b1;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_LENGTH;
      length_bytes_seen  <= 2'd0;
      length_accumulator <= '0;
      sample_bytes_left  <= '0;
      payload_bytes_left <= '0;
    end else begin
      phase              <= phase_next;
      length_bytes_seen  <= length_bytes_seen_next;
      length_accumulator <= length_accumulator_next;
      sample_bytes_left  <= sample_bytes_left_next;
      payload_bytes_left <= payload_bytes_left_next;
    end
  end

endmodule

### rtl/lpsc_queue.sv
module lpsc_queue import lpsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  lpsc_cmd_t   push_cmd,
  input  logic        pop,
  output lpsc_cmd_t   pop_cmd,
  output lpsc_qstat_t stat
);

  lpsc_cmd_t            slots [QDEPTH];
  logic [QPTR_BITS-1:0] head, head_next;
  logic [QPTR_BITS-1:0] tail, tail_next;
  logic [QPTR_BITS:0]   count, count_next;
  logic                 do_push;
  logic                 do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QPTR_BITS+1)'(QDEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_cmd    = slots[head];

  always_comb begin
    head_next  = do_pop ? head + 1'b1 : head;
    tail_next  = do_push ? tail + 1'b1 : tail;
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_cmd;
    end
  end

endmodule

### rtl/lpsc_back.sv
module lpsc_back import lpsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lpsc_cmd_t   pop_cmd,
  input  lpsc_qstat_t stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_start_code,
  output logic        last_of_run
);

  logic [1:0] sc_left, sc_left_next;
  logic       out_valid_next;
  logic [7:0] out_byte_next;
  logic       is_start_code_next;
  logic       last_of_run_next;
  logic       load_ok;

  assign load_ok = !out_valid || !out_stall;
  assign pop     = load_ok && (sc_left == 2'd0) && !stat.empty;

  always_comb begin
    sc_left_next       = sc_left;
    out_valid_next     = out_valid;
    out_byte_next      = out_byte;
    is_start_code_next = is_start_code;
    last_of_run_next   = last_of_run;
    if (load_ok) begin
      if (sc_left != 2'd0) begin
        // remaining start code bytes: 00 00 then 01
        out_valid_next     = 1'b1;
        out_byte_next      = (sc_left == 2'd1) ? SC_ONE : SC_ZERO;
        is_start_code_next = 1'b1;
        last_of_run_next   = (sc_left == 2'd1);
        sc_left_next       = sc_left - 2'd1;
      end else if (!stat.empty) begin
        out_valid_next = 1'b1;
        if (pop_cmd.start) begin
          out_byte_next      = SC_ZERO;
          is_start_code_next = 1'b1;
          last_of_run_next   = 1'b0;
          sc_left_next       = 2'(LEN_BYTES - 1);
        end else begin
          out_byte_next      = pop_cmd.data;
          is_start_code_next = 1'b0;
          last_of_run_next   = 1'b1;
        end
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_left   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      sc_left   <= sc_left_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_byte      <= out_byte_next;
    is_start_code <= is_start_code_next;
    last_of_run   <= last_of_run_next;
  end

endmodule

### rtl/length_prefix_to_start_code.sv
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  -----------------------------------------
// in       input      in_valid / in_stall  data_byte, first_of_sample, sample_size
// out      output     out_valid/out_stall  out_byte, is_start_code, last_of_run
//
// One input item is taken per cycle while the command queue has room.
// A payload byte is held in a queue slot, then in the output register; a completed
// length becomes four start code items, so the output port sets the pace then.
// Synchronous active-high rst clears framing state, queue and output valid.
// in_stall rises only when the four-entry command queue is full.
module length_prefix_to_start_code import lpsc_pkg::*; #(
  parameter int unsigned SAMPLE_SIZE_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              data_byte,
  input  logic                    first_of_sample,
  input  logic [SIZE_IN_BITS-1:0] sample_size,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_byte,
  output logic                    is_start_code,
  output logic                    last_of_run
);

  logic        in_fire;
  logic        push;
  logic        pop;
  lpsc_cmd_t   push_cmd;
  lpsc_cmd_t   pop_cmd;
  lpsc_qstat_t stat;

  // Hold off the source only when the queue cannot take another command
  assign in_stall = stat.full;
  assign in_fire  = in_valid && !in_stall;

  // Parse length headers and classify each byte
  lpsc_front #(
    .SAMPLE_SIZE_BITS(SAMPLE_SIZE_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_fire         (in_fire),
    .data_byte       (data_byte),
    .first_of_sample (first_of_sample),
    .sample_size     (sample_size),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  // Decouple the parser from the output stalls
  lpsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (stat)
  );

  // Expand commands into output items
  lpsc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_cmd       (pop_cmd),
    .stat          (stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .is_start_code (is_start_code),
    .last_of_run   (last_of_run)
  );

endmodule

### tb/sv/lpsc_frame_check.sv
module lpsc_frame_check
  import lpsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [7:0]              data_byte,
  input  logic                    first_of_sample,
  input  logic [SIZE_IN_BITS-1:0] sample_size,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [7:0]              out_byte,
  input  logic                    is_start_code,
  input  logic                    last_of_run,
  output int                      mismatches,
  output int                      pending,
  output int                      consumed,
  output int                      results,
  output int                      start_codes,
  output int                      drops
);

  typedef struct packed {
    logic [7:0] data;
    logic       sc;
    logic       last;
  } framed_t;

  // Predicted framing state
  lpsc_phase_t             ph;
  logic [1:0]              len_seen;
  logic [LEN_BITS-1:0]     len_acc;
  logic [SIZE_IN_BITS-1:0] sample_left;
  logic [LEN_BITS-1:0]     unit_left;

  framed_t framed_q[$];
  framed_t want;
  framed_t got;

  task automatic push_framed(input logic [7:0] b, input logic sc, input logic last);
    framed_t f;
    f.data = b;
    f.sc   = sc;
    f.last = last;
    framed_q.push_back(f);
  endtask

  // Advance the framing state by one input byte and queue what it emits.
  task automatic frame_byte(input logic [7:0] b, input logic first,
                            input logic [SIZE_IN_BITS-1:0] size);
    if (first) begin
      sample_left = size;
      ph          = PH_LENGTH;
      len_seen    = '0;
      len_acc     = '0;
      unit_left   = '0;
    end
    if (sample_left == 0) return;
    sample_left = sample_left - 1'b1;
    consumed++;
    case (ph)
      PH_LENGTH: begin
        len_acc = {len_acc[LEN_BITS-9:0], b};
        if (len_seen < 2'd3) begin
          len_seen++;
          return;
        end
        len_seen = '0;
        if (len_acc > LEN_BITS'(sample_left)) begin
          ph      = PH_DROP;
          len_acc = '0;
          drops++;
          return;
        end
        unit_left = len_acc;
        len_acc   = '0;
        ph        = (unit_left == 0) ? PH_LENGTH : PH_PAYLOAD;
        push_framed(SC_ZERO, 1'b1, 1'b0);
        push_framed(SC_ZERO, 1'b1, 1'b0);
        push_framed(SC_ZERO, 1'b1, 1'b0);
        push_framed(SC_ONE,  1'b1, 1'b1);
      end
      PH_PAYLOAD: begin
        push_framed(b, 1'b0, 1'b1);
        unit_left--;
        if (unit_left == 0) begin
          ph       = PH_LENGTH;
          len_seen = '0;
          len_acc  = '0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ph          = PH_LENGTH;
      len_seen    = '0;
      len_acc     = '0;
      sample_left = '0;
      unit_left   = '0;
      framed_q.delete();
      mismatches  = 0;
      pending     = 0;
      consumed    = 0;
      results     = 0;
      start_codes = 0;
      drops       = 0;
    end else begin
      // Compare first: a result taken at this edge comes from an earlier item.
      if (out_valid && !out_stall) begin
        got.data = out_byte;
        got.sc   = is_start_code;
        got.last = last_of_run;
        results++;
        if (is_start_code) start_codes++;
        if (framed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result byte %02h sc %0b last %0b",
                     $realtime, got.data, got.sc, got.last);
        end else begin
          want = framed_q.pop_front();
          if (got.data !== want.data || got.sc !== want.sc || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch, expected byte %02h sc %0b last %0b,",
                        " got %02h sc %0b last %0b"},
                       $realtime, want.data, want.sc, want.last,
                       got.data, got.sc, got.last);
          end
        end
      end
      if (in_valid && !in_stall)
        frame_byte(data_byte, first_of_sample, sample_size);
      pending = framed_q.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import lpsc_pkg::*;

  // Shapes of generated samples: clean framing plus the ways a sample goes wrong
  typedef enum int {
    SK_CLEAN,
    SK_LONG,
    SK_TAIL,
    SK_CUT,
    SK_NOISE,
    SK_HUGE,
    SK_EMPTY
  } sample_kind_e;

  // One input item as it goes onto the wire
  typedef struct packed {
    logic [7:0]              b;
    logic                    first;
    logic [SIZE_IN_BITS-1:0] size;
  } stim_t;

  logic                    clk             = 1'b0;
  logic                    rst             = 1'b1;
  logic                    in_valid        = 1'b0;
  logic                    in_stall;
  logic [7:0]              data_byte       = '0;
  logic                    first_of_sample = 1'b0;
  logic [SIZE_IN_BITS-1:0] sample_size     = '0;
  logic                    out_valid;
  logic                    out_stall       = 1'b0;
  logic [7:0]              out_byte;
  logic                    is_start_code;
  logic                    last_of_run;

  int mismatches;
  int pending;
  int consumed;
  int results;
  int start_codes;
  int drops;

  stim_t      stim_q[$];
  logic [7:0] body_q[$];

  // Idle modes are switched every few samples so each side sees both
  // stretches with random gaps and stretches at full rate.
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int hold_asks = 0;
  int hold_done = 0;
  int samples   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  length_prefix_to_start_code u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .first_of_sample (first_of_sample),
    .sample_size     (sample_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .is_start_code   (is_start_code),
    .last_of_run     (last_of_run)
  );

  lpsc_frame_check u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .first_of_sample (first_of_sample),
    .sample_size     (sample_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .is_start_code   (is_start_code),
    .last_of_run     (last_of_run),
    .mismatches      (mismatches),
    .pending         (pending),
    .consumed        (consumed),
    .results         (results),
    .start_codes     (start_codes),
    .drops           (drops)
  );

  // Queue one item for the sender.
  task automatic push_byte(input logic [7:0] b, input logic first,
                           input logic [SIZE_IN_BITS-1:0] size);
    stim_t s;
    s.b     = b;
    s.first = first;
    s.size  = size;
    stim_q.push_back(s);
  endtask

  // Append a 4-byte big-endian length and some payload bytes to the sample body.
  task automatic add_unit(input logic [31:0] len_field, input int n_payload);
    body_q.push_back(len_field[31:24]);
    body_q.push_back(len_field[23:16]);
    body_q.push_back(len_field[15:8]);
    body_q.push_back(len_field[7:0]);
    repeat (n_payload) body_q.push_back(8'($urandom()));
  endtask

  // Build one sample of the given shape and queue its bytes. Only the first
  // byte carries first_of_sample; the size field on the others is noise the
  // block must ignore, so it is randomized to toggle every bit.
  task automatic build_sample(input sample_kind_e kind, input bit big);
    int                      len;
    int                      keep;
    int                      n_extra;
    logic [31:0]             long_len;
    logic [SIZE_IN_BITS-1:0] size;
    body_q.delete();
    repeat ($urandom_range(1, 3)) begin
      if (big) len = $urandom_range(16, 24);
      else if ($urandom_range(0, 3) == 0) len = 0;
      else len = $urandom_range(1, 10);
      add_unit(len, len);
    end
    n_extra = 0;
    case (kind)
      SK_LONG: begin
        // Claim more payload than the sample still holds
        len = $urandom_range(0, 6);
        if ($urandom_range(0, 1) == 1) long_len = $urandom();
        else long_len = len + 1 + $urandom_range(0, 300);
        add_unit(long_len, len);
      end
      SK_TAIL:  repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom()));
      SK_HUGE:  add_unit($urandom() & 32'h00FF_FFFF, $urandom_range(0, 3));
      SK_NOISE: n_extra = $urandom_range(1, 4);
      default: ;
    endcase
    size = SIZE_IN_BITS'(body_q.size());
    keep = body_q.size();
    case (kind)
      SK_CUT:   keep = $urandom_range(1, body_q.size() - 1);
      SK_HUGE:  size = SIZE_IN_BITS'($urandom_range(size, 24'hFF_FFFF));
      SK_EMPTY: begin
        size = '0;
        keep = $urandom_range(1, 2);
      end
      default: ;
    endcase
    // Drop the tail of a cut sample; the next sample's first byte restarts framing
    while (body_q.size() > keep) body_q.delete(body_q.size() - 1);
    foreach (body_q[i])
      push_byte(body_q[i], i == 0, (i == 0) ? size : SIZE_IN_BITS'($urandom()));
    repeat (n_extra) push_byte(8'($urandom()), 1'b0, SIZE_IN_BITS'($urandom()));
  endtask

  // Drive queued items. Change inputs at the falling edge, hold each item
  // until a rising edge sees in_stall low, and leave valid high when the next
  // item follows without a gap.
  task automatic send_all();
    stim_t s;
    int    gap;
    while (stim_q.size() > 0) begin
      s   = stim_q.pop_front();
      gap = send_idle ? $urandom_range(0, 15) : 0;
      repeat (gap) @(negedge clk) in_valid <= 1'b0;
      @(negedge clk);
      in_valid        <= 1'b1;
      data_byte       <= s.b;
      first_of_sample <= s.first;
      sample_size     <= s.size;
      do @(posedge clk); while (in_stall);
    end
  endtask

  // Receiver: draw a stall length per result, or serve a long hold-off when
  // the stimulus asks for one, then take exactly one result.
  initial begin : recv_proc
    int n;
    forever begin
      if (hold_asks != hold_done) begin
        hold_done++;
        n = 300;
      end else begin
        n = recv_idle ? $urandom_range(0, 15) : 0;
      end
      repeat (n) @(negedge clk) out_stall <= 1'b1;
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict
  initial begin : stim_proc
    int           base;
    int           r;
    logic [1:0]   mode;
    sample_kind_e kind;

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed part. A stray byte before any sample is ignored.
    recv_idle = 1'b1;
    push_byte(8'hFF, 1'b0, 24'hFF_FFFF);
    // Empty sample: even the marked byte is ignored
    push_byte(8'hAA, 1'b1, 24'h00_0000);
    // Zero-length unit, a 1-byte unit, then a 3-byte tail too short for a length
    push_byte(8'h00, 1'b1, 24'd12);
    push_byte(8'h00, 1'b0, 24'h00_0000);
    push_byte(8'h00, 1'b0, 24'hFF_FFFF);
    push_byte(8'h00, 1'b0, 24'h00_0000);
    push_byte(8'h00, 1'b0, 24'h00_0000);
    push_byte(8'h00, 1'b0, 24'h00_0000);
    push_byte(8'h00, 1'b0, 24'h00_0000);
    push_byte(8'h01, 1'b0, 24'h00_0000);
    push_byte(8'hFF, 1'b0, 24'h00_0000);
    push_byte(8'hFF, 1'b0, 24'h00_0000);
    push_byte(8'hFF, 1'b0, 24'h00_0000);
    push_byte(8'hFF, 1'b0, 24'h00_0000);
    // Length one past what is left: the rest of the sample is dropped
    push_byte(8'h00, 1'b1, 24'd5);
    push_byte(8'h00, 1'b0, 24'h00_0000);
    push_byte(8'h00, 1'b0, 24'h00_0000);
    push_byte(8'h02, 1'b0, 24'h00_0000);
    push_byte(8'h5A, 1'b0, 24'h00_0000);
    // Largest sample, length exactly equal to what is left, restarted mid-unit
    push_byte(8'h00, 1'b1, 24'hFF_FFFF);
    push_byte(8'hFF, 1'b0, 24'h00_0000);
    push_byte(8'hFF, 1'b0, 24'h00_0000);
    push_byte(8'hFB, 1'b0, 24'h00_0000);
    push_byte(8'h80, 1'b0, 24'h00_0000);
    // Largest sample with the largest length: dropped
    push_byte(8'hFF, 1'b1, 24'hFF_FFFF);
    push_byte(8'hFF, 1'b0, 24'h00_0000);
    push_byte(8'hFF, 1'b0, 24'h00_0000);
    push_byte(8'hFF, 1'b0, 24'h00_0000);
    send_all();

    // Random part: mostly clean samples, the rest broken in one way or another.
    // Count only bytes that land inside a sample.
    base = consumed;
    while (consumed - base < 450) begin
      if (samples % 6 == 0) begin
        mode      = 2'($urandom_range(0, 3));
        send_idle = mode[0];
        recv_idle = mode[1];
      end
      if (samples == 8 || samples == 60) begin
        // Hold off the receiver while a long sample streams in at full rate,
        // so the command queue fills and in_stall rises.
        hold_asks++;
        send_idle = 1'b0;
        build_sample(SK_CLEAN, 1'b1);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) kind = SK_CLEAN;
        else if (r < 72) kind = SK_LONG;
        else if (r < 79) kind = SK_TAIL;
        else if (r < 86) kind = SK_CUT;
        else if (r < 91) kind = SK_NOISE;
        else if (r < 96) kind = SK_HUGE;
        else kind = SK_EMPTY;
        build_sample(kind, 1'b0);
      end
      send_all();
      samples++;
    end
    @(negedge clk) in_valid <= 1'b0;

    // Drain, then give the block time to show any stray result
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d random samples, %0d bytes inside samples, %0d results",
             samples, consumed, results);
    $display("%0d start code bytes, %0d units dropped, %0d long receiver hold-offs",
             start_codes, drops, hold_done);
    if (mismatches == 0 && pending == 0) begin
      $display("length_prefix_to_start_code regression: pass");
    end else begin
      $display("length_prefix_to_start_code regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("length_prefix_to_start_code regression: fail");
    $finish;
  end

endmodule
